/* rtl/bba_pkg.sv */
// Shared types and constants for the block bitmap allocator.
`default_nettype none
package bba_pkg;

    localparam int NUM_BLOCKS = 256;
    localparam int MAP_BYTES  = (NUM_BLOCKS + 7) / 8;
    localparam int BYTE_W     = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ALL_TAKEN = 8'hFF;
    localparam logic [7:0] FIRST_BIT = 8'h80;
    // Unused low bits of a partial last byte read as taken.
    localparam logic [7:0] LAST_PAD  = (NUM_BLOCKS % 8 == 0) ? 8'h00 :
                                       8'(ALL_TAKEN >> (NUM_BLOCKS % 8));

    typedef enum logic [1:0] {
        CMD_FIND  = 2'd0,
        CMD_SET   = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_FLIP  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] block_index;
    } req_t;

    typedef struct packed {
        logic [7:0] result_index;
        logic       bit_value;
        logic       full_res;
    } res_t;

    // Classified request held between front and back.
    typedef struct packed {
        cmd_t       op;
        logic [7:0] idx;
        logic       in_range;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_out_t;

endpackage
`default_nettype wire

/* rtl/block_bitmap_allocator.sv */
// Top level of the block bitmap allocator.
// Request side: a request (cmd, block_index) is taken at a rising edge with
//   push high and full low. A two-entry queue in the front end holds requests.
// Result side: while empty is low the oldest result (result_index, bit_value,
//   full_res) stands on res; it is taken at a rising edge with pop high.
// Each request gives exactly one result, in request order.
// Sequencing: the back end works on one request at a time and takes the next
//   only after the last result is loaded. Set, clear and flip pass through an
//   execute step; find passes through summary capture, byte search over the
//   registered summary bits and bit search in the chosen byte.
// Reset clears the whole occupancy map at once, so every block is free, and
//   empties the queue and the result register; requests are taken at once.
// When the receiver stalls, the back end holds its finished result until the
//   result register drains, and the front queue keeps taking requests until
//   full rises.
`default_nettype none
module block_bitmap_allocator
    import bba_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    output logic      full,
    input  wire req_t req,
    output logic      empty,
    input  wire logic pop,
    output res_t      res
);

    q_out_t q_out;
    logic   take;

    bba_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .q_out (q_out),
        .take  (take)
    );

    bba_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .q_out (q_out),
        .take  (take),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

endmodule
`default_nettype wire

/* rtl/bba_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module bba_front
    import bba_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    output logic        full,
    input  wire req_t   req,
    output q_out_t      q_out,
    input  wire logic   take
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    item_t             store [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    item_t             in_item;
    logic              do_push, do_pop;

    always_comb
    begin
        in_item.op       = cmd_t'(req.cmd);
        in_item.idx      = req.block_index;
        in_item.in_range = (32'(req.block_index) < 32'(NUM_BLOCKS));
    end

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_push    = push && !full;
    assign do_pop     = take && (count_reg != '0);
    assign q_out.valid = (count_reg != '0);
    assign q_out.item  = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

/* rtl/bba_back.sv */
// Back end: occupancy map, first-fit search and the result register.
`default_nettype none
module bba_back
    import bba_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire q_out_t q_out,
    output logic        take,
    output logic        empty,
    input  wire logic   pop,
    output res_t        res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_BIT,
        S_EXEC
    } state_t;

    state_t                         state_reg;
    logic [MAP_BYTES-1:0][7:0]      map_reg;
    logic [MAP_BYTES-1:0]           summary_reg;
    logic [MAP_BYTES-1:0]           row_full;
    item_t                          cur_reg;
    logic [BYTE_W-1:0]              byte_sel_reg;
    logic                           any_free_reg;
    logic                           out_valid_reg;
    res_t                           out_reg;

    logic [BYTE_W-1:0]              first_byte;
    logic [7:0]                     scan_row;
    logic [2:0]                     bit_pos;
    logic [BYTE_W+2:0]              found_idx;
    logic [BYTE_W-1:0]              exec_byte;
    logic [7:0]                     exec_mask;
    logic [7:0]                     exec_new;
    logic                           slot_free;
    logic                           res_load;

    function automatic logic [7:0] pad_mask(input logic [BYTE_W-1:0] b);
        return (b == BYTE_W'(MAP_BYTES - 1)) ? LAST_PAD : 8'h00;
    endfunction

    // Byte summary: set when no free block remains in that byte.
    always_comb
    begin
        for (int b = 0; b < MAP_BYTES; b++)
        begin
            row_full[b] = ((map_reg[b] | pad_mask(BYTE_W'(b))) == ALL_TAKEN);
        end
    end

    // Lowest byte with a free block, from the registered summary.
    always_comb
    begin
        first_byte = '0;
        for (int b = MAP_BYTES - 1; b >= 0; b--)
        begin
            if (!summary_reg[b])
            begin
                first_byte = BYTE_W'(b);
            end
        end
    end

    // Lowest free bit inside the chosen byte, most significant bit first.
    always_comb
    begin
        scan_row = map_reg[byte_sel_reg] | pad_mask(byte_sel_reg);
        bit_pos  = '0;
        for (int j = 7; j >= 0; j--)
        begin
            if (!scan_row[7 - j])
            begin
                bit_pos = 3'(j);
            end
        end
        found_idx = {byte_sel_reg, bit_pos};
    end

    always_comb
    begin
        exec_byte = BYTE_W'(cur_reg.idx >> 3);
        exec_mask = 8'(FIRST_BIT >> cur_reg.idx[2:0]);
        case (cur_reg.op)
            CMD_SET:   exec_new = map_reg[exec_byte] | exec_mask;
            CMD_CLEAR: exec_new = map_reg[exec_byte] & ~exec_mask;
            CMD_FLIP:  exec_new = map_reg[exec_byte] ^ exec_mask;
            default:   exec_new = map_reg[exec_byte];
        endcase
    end

    assign slot_free = !out_valid_reg || pop;
    assign res_load  = ((state_reg == S_BIT) || (state_reg == S_EXEC)) && slot_free;
    assign take      = (state_reg == S_IDLE) && q_out.valid;
    assign empty     = !out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            map_reg       <= '0;
            summary_reg   <= '0;
            cur_reg       <= '0;
            byte_sel_reg  <= '0;
            any_free_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            // Drop the taken result unless a new one replaces it.
            if (pop && out_valid_reg && !res_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_out.valid)
                    begin
                        cur_reg     <= q_out.item;
                        summary_reg <= row_full;
                        state_reg   <= (q_out.item.op == CMD_FIND) ? S_SCAN : S_EXEC;
                    end
                end
                S_SCAN:
                begin
                    byte_sel_reg <= first_byte;
                    any_free_reg <= !(&summary_reg);
                    state_reg    <= S_BIT;
                end
                S_BIT:
                begin
                    // Hold until the result register can take the answer.
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (any_free_reg)
                        begin
                            out_reg.result_index <= 8'(found_idx);
                            out_reg.bit_value    <= 1'b0;
                            out_reg.full_res     <= 1'b0;
                        end
                        else
                        begin
                            out_reg.result_index <= '0;
                            out_reg.bit_value    <= 1'b1;
                            out_reg.full_res     <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_EXEC:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg        <= 1'b1;
                        out_reg.result_index <= cur_reg.idx;
                        out_reg.full_res     <= 1'b0;
                        if (cur_reg.in_range)
                        begin
                            map_reg[exec_byte] <= exec_new;
                            out_reg.bit_value  <= |(exec_new & exec_mask);
                        end
                        else
                        begin
                            // Drop writes beyond the map.
                            out_reg.bit_value  <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
